### design/fat12_cluster_chain_walker_top_defines.svh
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top_defines
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FCW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcw same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcw next-cycle check failed");

`endif

### design/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcw_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ENTRY_W     = 12;
  localparam int unsigned PIDX_W      = 11;
  localparam int unsigned BYTES_W     = 24;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned OFFS_W      = 21;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_OPEN = 2'd1,
    OP_NEXT = 2'd2
  } fcw_op_e;

  // controller -> datapath / output buffer
  typedef struct packed {
    logic load;
    logic open;
    logic next;
    logic rd_en;
    logic cur_upd;
    logic push;
  } fcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic open_last;
    logic cur_last;
    logic active;
  } fcw_dp_status_t;

  typedef struct packed {
    logic               status;
    logic [ENTRY_W-1:0] cluster;
    logic [OFFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]   byte_count;
    logic               last;
  } fcw_result_t;

endpackage

`default_nettype wire

### design/fcw_ctrl.sv
// ----------------------------------------------------------------------------
// fcw_ctrl
// Request sequencer: decodes the operation and waits out the table read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [fcw_pkg::OP_W-1:0]   in_op_i,
  input  logic                       buf_full_i,
  input  fcw_pkg::fcw_dp_status_t    dp_status_i,
  output logic                       in_ready_o,
  output fcw_pkg::fcw_cmd_t          cmd_o
);
  import fcw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RDWAIT = 2'b10
  } fcw_state_e;

  fcw_state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !buf_full_i;
        if (in_valid_i && !buf_full_i) begin
          unique case (in_op_i)
            OP_LOAD: begin
              cmd_o.load = 1'b1;
            end
            OP_OPEN: begin
              cmd_o.open  = 1'b1;
              cmd_o.push  = 1'b1;
              cmd_o.rd_en = !dp_status_i.open_last;
            end
            OP_NEXT: begin
              cmd_o.next  = 1'b1;
              cmd_o.push  = 1'b1;
              cmd_o.rd_en = dp_status_i.active && !dp_status_i.cur_last;
            end
            default: ;
          endcase
          if (cmd_o.rd_en) state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        // table data is registered now; follow the link
        cmd_o.cur_upd = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/fcw_datapath.sv
// ----------------------------------------------------------------------------
// fcw_datapath
// Allocation table memory, chain registers and chunk result arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_datapath #(
  parameter int unsigned FAT_ENTRIES   = 4096,
  parameter int unsigned CLUSTER_BYTES = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcw_pkg::fcw_cmd_t             cmd_i,
  input  logic [fcw_pkg::PIDX_W-1:0]    pair_index_i,
  input  logic [fcw_pkg::BYTES_W-1:0]   packed_bytes_i,
  input  logic [fcw_pkg::ENTRY_W-1:0]   start_cluster_i,
  input  logic [fcw_pkg::SIZE_W-1:0]    file_size_i,
  output fcw_pkg::fcw_dp_status_t       status_o,
  output fcw_pkg::fcw_result_t          result_o
);
  import fcw_pkg::*;

  // table is kept as entry pairs: even entries in lo_mem, odd in hi_mem
  localparam int unsigned LO_PAIRS = (FAT_ENTRIES + 1) / 2;
  localparam int unsigned HI_PAIRS = FAT_ENTRIES / 2;
  localparam int unsigned PAW      = $clog2(LO_PAIRS);
  localparam int unsigned PROD_W   = ENTRY_W + SIZE_W;
  localparam logic [SIZE_W-1:0] CB = SIZE_W'(CLUSTER_BYTES);

  logic [ENTRY_W-1:0] lo_mem [LO_PAIRS];
  logic [ENTRY_W-1:0] hi_mem [LO_PAIRS];

  logic [ENTRY_W-1:0] rd_lo_q, rd_hi_q;
  logic               rd_sel_q, rd_oob_q;

  logic [ENTRY_W-1:0] cur_q, cur_d;
  logic [SIZE_W-1:0]  rem_q, rem_d;
  logic               active_q, active_d;

  logic               wr_lo, wr_hi;
  logic [ENTRY_W-1:0] chunk_clu;
  logic [SIZE_W-1:0]  chunk_rem;
  logic               chunk_last;
  logic               chunk_go;
  logic [PROD_W-1:0]  offs_prod;
  logic [ENTRY_W-1:0] link;

  assign wr_lo = cmd_i.load && (32'(pair_index_i) < 32'(LO_PAIRS));
  assign wr_hi = cmd_i.load && (32'(pair_index_i) < 32'(HI_PAIRS));

  assign status_o.open_last = file_size_i <= CB;
  assign status_o.cur_last  = rem_q <= CB;
  assign status_o.active    = active_q;

  assign chunk_clu  = cmd_i.open ? start_cluster_i : cur_q;
  assign chunk_rem  = cmd_i.open ? file_size_i : rem_q;
  assign chunk_last = cmd_i.open ? status_o.open_last : status_o.cur_last;
  assign chunk_go   = cmd_i.open || (cmd_i.next && active_q);
  assign offs_prod  = PROD_W'(chunk_clu) * PROD_W'(CLUSTER_BYTES);

  always_ff @(posedge clk_i) begin
    if (wr_lo) lo_mem[pair_index_i[PAW-1:0]] <= packed_bytes_i[ENTRY_W-1:0];
    if (wr_hi) hi_mem[pair_index_i[PAW-1:0]] <= packed_bytes_i[2*ENTRY_W-1:ENTRY_W];
    if (cmd_i.rd_en) begin
      rd_lo_q  <= lo_mem[chunk_clu[PAW:1]];
      rd_hi_q  <= hi_mem[chunk_clu[PAW:1]];
      rd_sel_q <= chunk_clu[0];
      rd_oob_q <= 32'(chunk_clu) >= 32'(FAT_ENTRIES);
    end
  end

  // clusters past the table link to zero
  assign link = rd_oob_q ? '0 : (rd_sel_q ? rd_hi_q : rd_lo_q);

  always_comb begin
    cur_d    = cur_q;
    rem_d    = rem_q;
    active_d = active_q;
    if (chunk_go) begin
      cur_d    = chunk_clu;
      rem_d    = chunk_last ? '0 : chunk_rem - CB;
      active_d = !chunk_last;
    end else if (cmd_i.cur_upd) begin
      cur_d = link;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      rem_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      rem_q    <= rem_d;
      active_q <= active_d;
    end
  end

  always_comb begin
    result_o = '0;
    if (cmd_i.next && !active_q) begin
      result_o.status = 1'b1;
    end else begin
      result_o.cluster     = chunk_clu;
      result_o.byte_offset = offs_prod[OFFS_W-1:0];
      result_o.byte_count  = chunk_last ? chunk_rem[CNT_W-1:0] : CB[CNT_W-1:0];
      result_o.last        = chunk_last;
    end
  end

endmodule

`default_nettype wire

### design/fcw_out_buf.sv
// ----------------------------------------------------------------------------
// fcw_out_buf
// Two-slot result buffer: output register plus one skid slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fcw_pkg::fcw_result_t result_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output fcw_pkg::fcw_result_t out_result_o,
  output logic                 full_o
);
  import fcw_pkg::*;

  fcw_result_t out_q, out_d, pend_q, pend_d;
  logic        out_v_q, out_v_d, pend_v_q, pend_v_d;
  logic        pop, out_free;

  assign pop      = out_v_q && out_ready_i;
  assign out_free = !out_v_q || pop;

  always_comb begin
    out_d    = out_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    pend_v_d = pend_v_q;
    if (pop) out_v_d = 1'b0;
    if (pend_v_q && out_free) begin
      out_d    = pend_q;
      out_v_d  = 1'b1;
      pend_v_d = 1'b0;
    end
    // push only comes while the skid slot is empty
    if (push_i) begin
      if (out_free && !pend_v_q) begin
        out_d   = result_i;
        out_v_d = 1'b1;
      end else begin
        pend_d   = result_i;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;
  assign full_o       = pend_v_q;

endmodule

`default_nettype wire

### design/fat12_cluster_chain_walker_top.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// FAT12 allocation table store and cluster chain walker.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  carries
//  s_axis   in   s_axis_tvalid/tready       load, open and next requests
//  m_axis   out  m_axis_tvalid/tready       chunk or status results
//
//  Load, op code 3 and a next with no file open finish on accept. Open and next
//  on a chunk that is not the last also read the table and register the link
//  before the next request is taken. A result is registered in the output
//  buffer on accept.
//  Reset clears chain, controller and output valid state; the table is undefined until loaded.
//  One result may wait at the output while the next request is taken; with
//  both slots full, s_axis_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_chain_walker_top #(
  parameter int unsigned FAT_ENTRIES   = 4096,
  parameter int unsigned CLUSTER_BYTES = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pair_index[10:0], packed_bytes[34:11], start_cluster[46:35],
  // file_size[78:47], zero[79]
  input  logic [fcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // operation[1:0]
  input  logic [fcw_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cluster[11:0], byte_offset[32:12], byte_count[42:33], zero[47:43]
  output logic [fcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import fcw_pkg::*;

  fcw_cmd_t       cmd;
  fcw_dp_status_t dp_status;
  fcw_result_t    result, out_result;
  logic           buf_full;

  fcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .buf_full_i  (buf_full),
    .dp_status_i (dp_status),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  fcw_datapath #(
    .FAT_ENTRIES   (FAT_ENTRIES),
    .CLUSTER_BYTES (CLUSTER_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .pair_index_i    (s_axis_tdata[10:0]),
    .packed_bytes_i  (s_axis_tdata[34:11]),
    .start_cluster_i (s_axis_tdata[46:35]),
    .file_size_i     (s_axis_tdata[78:47]),
    .status_o        (dp_status),
    .result_o        (result)
  );

  fcw_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd.push),
    .result_i     (result),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_result_o (out_result),
    .full_o       (buf_full)
  );

  assign m_axis_tdata = {5'b0, out_result.byte_count, out_result.byte_offset,
                         out_result.cluster};
  assign m_axis_tuser = out_result.status;
  assign m_axis_tlast = out_result.last;

endmodule

`default_nettype wire

### design/fcw_checker.sv
// ----------------------------------------------------------------------------
// fcw_checker
// Port-level checks on the result stream of the chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fat12_cluster_chain_walker_top_defines.svh"

module fcw_checker #(
  parameter int unsigned CLUSTER_BYTES = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [fcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast
);
  import fcw_pkg::*;

  localparam int unsigned PROD_W = ENTRY_W + SIZE_W;
  localparam logic [SIZE_W-1:0] CB = SIZE_W'(CLUSTER_BYTES);

  logic [PROD_W-1:0]      offs_prod;
  logic [CNT_W-1:0]       full_count;
  logic [OUT_TDATA_W+1:0] out_word;
  logic                   out_stall, status_v, chunk_v;

  assign offs_prod  = PROD_W'(m_axis_tdata[11:0]) * PROD_W'(CLUSTER_BYTES);
  assign full_count = CB[CNT_W-1:0];
  assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign status_v   = m_axis_tvalid && m_axis_tuser;
  assign chunk_v    = m_axis_tvalid && !m_axis_tuser;

  `FCW_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
  `FCW_ASSERT_SAME(a_status_clean, status_v, (m_axis_tdata == '0) && !m_axis_tlast)
  `FCW_ASSERT_SAME(a_full_chunk, chunk_v && !m_axis_tlast, m_axis_tdata[42:33] == full_count)
  `FCW_ASSERT_SAME(a_offset, chunk_v, m_axis_tdata[32:12] == offs_prod[OFFS_W-1:0])

endmodule

bind fat12_cluster_chain_walker_top fcw_checker #(
  .CLUSTER_BYTES (CLUSTER_BYTES)
) u_fcw_checker (.*);

`default_nettype wire
